// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds on this edge, consequent on the same edge
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// antecedent holds on this edge, consequent on the next edge
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/ssrs_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helpers for the shadow return stack checker
package ssrs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = 32;
    localparam int DEPTH_W     = 7;

    localparam logic [2:0] OUT_PUSHED   = 3'd0;
    localparam logic [2:0] OUT_FILTERED = 3'd1;
    localparam logic [2:0] OUT_MATCHED  = 3'd2;
    localparam logic [2:0] OUT_EMPTY    = 3'd3;
    localparam logic [2:0] OUT_MISMATCH = 3'd4;
    localparam logic [2:0] OUT_OVERFLOW = 3'd5;
    localparam logic [2:0] OUT_HALTED   = 3'd6;

    localparam logic [7:0] CALL_REL_OPC = 8'he8;

    typedef logic [ADDR_W-1:0] addr_t;

    // shift controls broadcast along the row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    function automatic logic call_filtered(
        input logic       ok,
        input logic [7:0] b0,
        input logic [7:0] b2
    );
        logic hit;
        hit = (b2 == 8'h6e) || (b2 == 8'h6d) || (b2 == 8'h6c) ||
              (b2 == 8'h08) || (b2 == 8'h6b) || (b2 == 8'h6f);
        return !ok || ((b0 == CALL_REL_OPC) && hit);
    endfunction

endpackage

// ----- design/ssrs_evt_if.sv -----
`timescale 1ns / 1ps
// input channel carrying one call or return event word
interface ssrs_evt_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [31:0] inst_addr;
    logic [3:0] inst_size;
    logic       fetch_ok;
    logic [7:0] first_opcode_byte;
    logic [7:0] third_opcode_byte;
    logic [31:0] return_word;

    modport source (
        output valid, cmd, inst_addr, inst_size, fetch_ok,
               first_opcode_byte, third_opcode_byte, return_word,
        input  ready
    );
    modport sink (
        input  valid, cmd, inst_addr, inst_size, fetch_ok,
               first_opcode_byte, third_opcode_byte, return_word,
        output ready
    );
endinterface

// ----- design/ssrs_res_if.sv -----
`timescale 1ns / 1ps
// result channel carrying one outcome word per event
interface ssrs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic [6:0] depth;
    logic       alarm;

    modport source (
        output valid, outcome, depth, alarm,
        input  ready
    );
    modport sink (
        input  valid, outcome, depth, alarm,
        output ready
    );
endinterface

// ----- design/ssrs_cell.sv -----
`timescale 1ns / 1ps
// one stack entry: takes the word above on a push, the word below on a pop
module ssrs_cell (
    input  logic            clk,
    input  ssrs_pkg::shift_t shift,
    input  ssrs_pkg::addr_t  from_above,
    input  ssrs_pkg::addr_t  from_below,
    output ssrs_pkg::addr_t  data
);

    ssrs_pkg::addr_t data_reg;
    ssrs_pkg::addr_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift.push)
        begin
            data_next = from_above;
        end
        else if (shift.pop)
        begin
            data_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/shadow_return_stack_checker.sv -----
`timescale 1ns / 1ps
// Shadow return stack checker: a call pushes its return address (address plus
// length) onto a row of STACK_DEPTH cells that shift down on a push and up on a
// pop, so the top entry is always sitting in the first cell's register and a
// return is compared against it directly. One event is taken every cycle while
// the input is ready, and its result word appears on the output register the
// cycle after; the input stays ready whenever that register is empty or being
// drained in the same cycle. A return address mismatch sets a sticky alarm
// after which every event is reported as ignored. No clearing pass is needed
// after reset: only entries below the fill count are ever read.
module shadow_return_stack_checker (
    input  logic       clk,
    input  logic       rst_n,
    ssrs_evt_if.sink   evt,
    ssrs_res_if.source res
);

    localparam int LAST = ssrs_pkg::STACK_DEPTH - 1;

    logic [ssrs_pkg::DEPTH_W-1:0] count_reg;
    logic [ssrs_pkg::DEPTH_W-1:0] count_next;
    logic                         alarm_reg;
    logic                         alarm_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic [2:0]                   outcome_reg;
    logic [2:0]                   outcome_next;

    ssrs_pkg::shift_t shift;
    ssrs_pkg::addr_t  push_word;
    ssrs_pkg::addr_t  cell_data [ssrs_pkg::STACK_DEPTH];
    logic             accept;
    logic             full;

    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;
    assign full      = (count_reg == ssrs_pkg::DEPTH_W'(ssrs_pkg::STACK_DEPTH));
    assign push_word = evt.inst_addr + {28'd0, evt.inst_size};

    always_comb
    begin
        shift        = '0;
        count_next   = count_reg;
        alarm_next   = alarm_reg;
        outcome_next = outcome_reg;
        if (accept)
        begin
            priority if (alarm_reg)
            begin
                outcome_next = ssrs_pkg::OUT_HALTED;
            end
            else if (!evt.cmd)
            begin
                priority if (ssrs_pkg::call_filtered(evt.fetch_ok, evt.first_opcode_byte,
                                                     evt.third_opcode_byte))
                begin
                    outcome_next = ssrs_pkg::OUT_FILTERED;
                end
                else if (full)
                begin
                    outcome_next = ssrs_pkg::OUT_OVERFLOW;
                end
                else
                begin
                    shift.push   = 1'b1;
                    count_next   = count_reg + 1'b1;
                    outcome_next = ssrs_pkg::OUT_PUSHED;
                end
            end
            else if (count_reg == '0)
            begin
                outcome_next = ssrs_pkg::OUT_EMPTY;
            end
            else
            begin
                shift.pop  = 1'b1;
                count_next = count_reg - 1'b1;
                if (cell_data[0] == evt.return_word)
                begin
                    outcome_next = ssrs_pkg::OUT_MATCHED;
                end
                else
                begin
                    alarm_next   = 1'b1;
                    outcome_next = ssrs_pkg::OUT_MISMATCH;
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            alarm_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            alarm_reg     <= alarm_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
    end

    // the state registers already hold the values after the last accepted word
    assign res.valid   = res_valid_reg;
    assign res.outcome = outcome_reg;
    assign res.depth   = count_reg;
    assign res.alarm   = alarm_reg;

    for (genvar i = 0; i < ssrs_pkg::STACK_DEPTH; i++)
    begin : g_cell
        ssrs_pkg::addr_t above;
        ssrs_pkg::addr_t below;

        if (i == 0)
        begin : g_head
            assign above = push_word;
        end
        else
        begin : g_body
            assign above = cell_data[i-1];
        end

        if (i == LAST)
        begin : g_tail
            assign below = '0;
        end
        else
        begin : g_link
            assign below = cell_data[i+1];
        end

        ssrs_cell u_cell (
            .clk        (clk),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .data       (cell_data[i])
        );
    end

endmodule

// ----- design/ssrs_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the shadow return stack checker, bound to the top level
`include "assert_macros.svh"

module ssrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_outcome,
    input logic [6:0] res_depth,
    input logic       res_alarm
);

    logic mism;
    logic halted;
    logic empty;
    logic stall;

    assign mism   = res_valid && (res_outcome == ssrs_pkg::OUT_MISMATCH);
    assign halted = res_valid && (res_outcome == ssrs_pkg::OUT_HALTED);
    assign empty  = res_valid && (res_outcome == ssrs_pkg::OUT_EMPTY);
    assign stall  = res_valid && !res_ready;

    `ASSERT_IMP(a_mismatch_alarm, clk, rst_n, mism, res_alarm)
    `ASSERT_IMP(a_halted_alarm, clk, rst_n, halted, res_alarm)
    `ASSERT_IMP(a_empty_depth, clk, rst_n, empty, res_depth == 7'd0)
    `ASSERT_NXT(a_stall_hold, clk, rst_n, stall, res_valid && $stable(res_outcome))

endmodule

bind shadow_return_stack_checker ssrs_checker u_ssrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_outcome (res.outcome),
    .res_depth   (res.depth),
    .res_alarm   (res.alarm)
);
